// File: hdl/farrb_pkg.sv
`default_nettype none

package farrb_pkg;

  localparam int ADDR_W      = 32;
  localparam int PORT_W      = 16;
  localparam int PROTO_W     = 8;
  localparam int PKT_W       = 5;
  localparam int SLOT_W      = 3;
  localparam int TOTAL_W     = 32;
  localparam int KEY_W       = 2 * ADDR_W + 2 * PORT_W + PROTO_W;
  localparam int SRV_CNT_W   = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int ADDR_REGS   = 6;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_SERVER_COUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERVER_ADDR_0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SERVER_ADDR_LAST = 3'd6;

  localparam logic [SRV_CNT_W-1:0] SERVER_COUNT_RST = 3'd6;
  localparam logic [ADDR_W-1:0] SERVER_ADDR_RST [ADDR_REGS] = '{
    32'd4321, 32'd5432, 32'd6543, 32'd7654, 32'd8765, 32'd9876
  };

  typedef struct packed {
    logic [ADDR_W-1:0]  src_addr;
    logic [ADDR_W-1:0]  dst_key;
    logic [PORT_W-1:0]  src_port;
    logic [PORT_W-1:0]  dst_port;
    logic [PROTO_W-1:0] protocol;
    logic [PKT_W-1:0]   rec_pkts;
  } in_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  dst_addr;
    logic [SLOT_W-1:0]  server_slot;
    logic               new_flow;
    logic               table_full;
    logic [TOTAL_W-1:0] slot_packets;
  } out_rsp_t;

  typedef struct packed {
    logic start;    // latch request, restart table scan
    logic scan;     // read next table entry
    logic resolve;  // pick slot, insert on miss unless table full
    logic emit;     // update slot total, load result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic exhausted;
    logic out_free;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

endpackage

`default_nettype wire

// File: hdl/farrb_ctrl.sv
`default_nettype none

module farrb_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire farrb_pkg::dp_status_t status,
  output farrb_pkg::ctrl_cmd_t       cmd
);
  import farrb_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_stall    = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status.hit || status.exhausted) begin
          cmd.resolve = 1'b1;
          state_nxt   = ST_UPDATE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      ST_UPDATE: begin
        // hold here until the result register can take the request
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/farrb_dp.sv
`default_nettype none

module farrb_dp #(
  parameter int FLOW_ENTRIES = 64,
  parameter int MAX_SERVERS  = 6
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire farrb_pkg::in_req_t                  in_data,
  input  wire logic                                cfg_we,
  input  wire logic [farrb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [farrb_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire farrb_pkg::ctrl_cmd_t                cmd,
  output farrb_pkg::dp_status_t                    status,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output farrb_pkg::out_rsp_t                      out_data
);
  import farrb_pkg::*;

  localparam int IDX_W     = $clog2(FLOW_ENTRIES);
  localparam int CNT_W     = $clog2(FLOW_ENTRIES + 1);
  localparam int ENTRY_W   = KEY_W + SLOT_W;
  localparam int TOT_IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam logic [CNT_W-1:0] TABLE_SIZE = CNT_W'(FLOW_ENTRIES);
  localparam logic [SLOT_W:0]  SERVERS_MAX = (SLOT_W + 1)'(MAX_SERVERS);

  // flow table: key and assigned slot, filled in order
  logic [ENTRY_W-1:0] mem [FLOW_ENTRIES];
  logic [ENTRY_W-1:0] rdata_r;

  logic [SRV_CNT_W-1:0] server_count_r;
  logic [ADDR_W-1:0]    server_addr_r [ADDR_REGS];
  logic [TOTAL_W-1:0]   totals_r [MAX_SERVERS];

  logic [CNT_W-1:0]  used_r;
  logic [CNT_W-1:0]  rd_idx_r;
  logic              chk_v_r;
  logic [SLOT_W-1:0] rr_r;

  logic [KEY_W-1:0]  key_r;
  logic [PKT_W-1:0]  pkts_r;
  logic [SLOT_W-1:0] slot_r;
  logic              fresh_r;
  logic              full_r;

  logic              out_valid_r;
  out_rsp_t          out_data_r;

  logic [SLOT_W:0]     count_eff;
  logic [SLOT_W-1:0]   rr_slot;
  logic [SLOT_W:0]     rr_inc;
  logic [SLOT_W-1:0]   rr_nxt;
  logic [SLOT_W-1:0]   hit_slot;
  logic                tbl_full;
  logic                hit;
  logic [TOTAL_W:0]    sum;
  logic [TOTAL_W-1:0]  total_new;
  logic [ADDR_W-1:0]   addr_sel;
  logic [CFG_IDX_W-1:0] addr_idx;

  // effective server count: 0 acts as 1, clipped to MAX_SERVERS
  always_comb begin
    count_eff = {1'b0, server_count_r};
    if (server_count_r == '0) begin
      count_eff = (SLOT_W + 1)'(1);
    end else if (count_eff > SERVERS_MAX) begin
      count_eff = SERVERS_MAX;
    end
  end

  assign rr_slot  = ({1'b0, rr_r} < count_eff) ? rr_r : '0;
  assign rr_inc   = {1'b0, rr_slot} + (SLOT_W + 1)'(1);
  assign rr_nxt   = (rr_inc >= count_eff) ? '0 : rr_inc[SLOT_W-1:0];
  assign hit_slot = ({1'b0, rdata_r[SLOT_W-1:0]} >= SERVERS_MAX) ? '0 :
                    rdata_r[SLOT_W-1:0];
  assign tbl_full = (used_r >= TABLE_SIZE);
  assign hit      = chk_v_r && (rdata_r[ENTRY_W-1:SLOT_W] == key_r);

  assign status.hit       = hit;
  assign status.exhausted = !chk_v_r && (rd_idx_r == used_r);
  assign status.out_free  = !out_valid_r || !out_stall;

  assign sum       = {1'b0, totals_r[slot_r[TOT_IDX_W-1:0]]} + (TOTAL_W + 1)'(pkts_r);
  assign total_new = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
  assign addr_sel  = (slot_r < SLOT_W'(ADDR_REGS)) ? server_addr_r[slot_r] : '0;
  assign addr_idx  = cfg_index - REG_SERVER_ADDR_0;

  always_ff @(posedge clk) begin
    if (cmd.scan && (rd_idx_r < used_r)) begin
      rdata_r <= mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve && !hit && !tbl_full) begin
      mem[used_r[IDX_W-1:0]] <= {key_r, rr_slot};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_count_r <= SERVER_COUNT_RST;
      for (int i = 0; i < ADDR_REGS; i++) begin
        server_addr_r[i] <= SERVER_ADDR_RST[i];
      end
      for (int i = 0; i < MAX_SERVERS; i++) begin
        totals_r[i] <= '0;
      end
      used_r      <= '0;
      rd_idx_r    <= '0;
      chk_v_r     <= 1'b0;
      rr_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SERVER_COUNT) begin
          server_count_r <= cfg_data[SRV_CNT_W-1:0];
        end else if (cfg_index >= REG_SERVER_ADDR_0 &&
                     cfg_index <= REG_SERVER_ADDR_LAST) begin
          server_addr_r[addr_idx] <= cfg_data[ADDR_W-1:0];
        end
      end

      if (cmd.start) begin
        rd_idx_r <= '0;
        chk_v_r  <= 1'b0;
      end else if (cmd.scan) begin
        if (rd_idx_r < used_r) begin
          rd_idx_r <= rd_idx_r + CNT_W'(1);
          chk_v_r  <= 1'b1;
        end else begin
          chk_v_r  <= 1'b0;
        end
      end

      if (cmd.resolve && !hit) begin
        rr_r <= rr_nxt;
        if (!tbl_full) begin
          used_r <= used_r + CNT_W'(1);
        end
      end

      if (cmd.emit) begin
        totals_r[slot_r[TOT_IDX_W-1:0]] <= total_new;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r  <= {in_data.src_addr, in_data.dst_key, in_data.src_port,
                 in_data.dst_port, in_data.protocol};
      pkts_r <= in_data.rec_pkts;
    end
    if (cmd.resolve) begin
      slot_r  <= hit ? hit_slot : rr_slot;
      fresh_r <= !hit;
      full_r  <= !hit && tbl_full;
    end
    if (cmd.emit) begin
      out_data_r.dst_addr     <= addr_sel;
      out_data_r.server_slot  <= slot_r;
      out_data_r.new_flow     <= fresh_r;
      out_data_r.table_full   <= full_r;
      out_data_r.slot_packets <= total_new;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: hdl/flow_affinity_round_robin_balancer_top.sv
`default_nettype none

// channel   direction  handshake            payload
// in_       input      in_valid / in_stall   farrb_pkg::in_req_t
// out_      output     out_valid / out_stall farrb_pkg::out_rsp_t
// cfg_      input      cfg_we                cfg_index, cfg_data
//
// One request at a time. A request is taken in the idle state, then the flow
// table is scanned one stored entry at a time through the single table read
// port (a hit stops the scan early), then the update state loads the result.
// Synchronous active-low reset; the table needs no clearing pass, since the
// fill count marks which entries hold flows. A stalled result waits in the
// output register while the next request is already taken and searched.

module flow_affinity_round_robin_balancer_top #(
  parameter int FLOW_ENTRIES = 64,
  parameter int MAX_SERVERS  = 6
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire farrb_pkg::in_req_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output farrb_pkg::out_rsp_t                   out_data,
  input  wire logic                             cfg_we,
  input  wire logic [farrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [farrb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import farrb_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  farrb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  farrb_dp #(
    .FLOW_ENTRIES (FLOW_ENTRIES),
    .MAX_SERVERS  (MAX_SERVERS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
